// ===== rtl/m65_pkg.sv =====
// Shared constants, types and helpers for the mini 6502 step unit.
package m65_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_SET_PC  = 2'd2,
    KIND_STEP    = 2'd3
  } kind_t;

  localparam logic [7:0] OP_LDA = 8'hA9;
  localparam logic [7:0] OP_LDX = 8'hA2;
  localparam logic [7:0] OP_LDY = 8'hA0;
  localparam logic [7:0] OP_STA = 8'h8D;
  localparam logic [7:0] OP_STY = 8'h8C;
  localparam logic [7:0] OP_BRK = 8'h00;

  localparam logic [15:0] RESET_VECTOR    = 16'hFFFC;
  localparam logic [15:0] RESET_VECTOR_HI = RESET_VECTOR + 16'd1;
  localparam logic [7:0]  FLAG_Z          = 8'h02;
  localparam logic [7:0]  FLAG_N          = 8'h80;
  localparam logic [7:0]  STATUS_RESET    = 8'h20;

  localparam logic [2:0] CYC_NONE  = 3'd0;
  localparam logic [2:0] CYC_LOAD  = 3'd2;
  localparam logic [2:0] CYC_STORE = 3'd4;
  localparam logic [2:0] CYC_BRK   = 3'd7;

  typedef struct packed {
    logic [15:0] prog_counter;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  status;
    logic        is_halted;
    logic [2:0]  step_cycles;
    logic        bad_opcode;
  } res_t;

  function automatic logic [7:0] zn_update(input logic [7:0] st, input logic [7:0] v);
    logic [7:0] s;
    s = st & ~(FLAG_Z | FLAG_N);
    if (v == 8'h00) s = s | FLAG_Z;
    if (v[7]) s = s | FLAG_N;
    return s;
  endfunction

endpackage

// ===== rtl/m65_ram.sv =====
// Generic single-port RAM with registered read.
module m65_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/m65_seq.sv =====
// Request sequencer: CPU registers, memory port control and instruction execution.
module m65_seq import m65_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  kind_t       in_kind,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_value,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_EXEC = 10'b0000000100,
    S_VLO  = 10'b0000001000,
    S_VHI  = 10'b0000010000,
    S_OP   = 10'b0000100000,
    S_OPR  = 10'b0001000000,
    S_ADL  = 10'b0010000000,
    S_ADH  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t                 state;
  logic [ADDR_BITS-1:0]   clr_addr;
  kind_t                  kind;
  logic [15:0]            address;
  logic [7:0]             value;
  logic [15:0]            pc;
  logic [7:0]             acc;
  logic [7:0]             idx_x;
  logic [7:0]             idx_y;
  logic [7:0]             status;
  logic                   halted;
  logic [7:0]             op;
  logic [7:0]             lo;
  logic [2:0]             cycles;
  logic                   bad;

  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_addr;
  logic [7:0]             mem_wdata;
  logic [7:0]             mem_rdata;
  logic [15:0]            store_addr;

  m65_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign store_addr = {mem_rdata, lo};

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pc[ADDR_BITS-1:0];
    mem_wdata = value;
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = 8'h00;
      end
      S_EXEC: begin
        unique case (kind)
          KIND_WRITE: begin
            mem_we   = 1'b1;
            mem_addr = address[ADDR_BITS-1:0];
          end
          KIND_RESTART: mem_addr = RESET_VECTOR[ADDR_BITS-1:0];
          KIND_SET_PC:  mem_addr = pc[ADDR_BITS-1:0];
          KIND_STEP:    mem_addr = pc[ADDR_BITS-1:0];
        endcase
      end
      S_VLO: mem_addr = RESET_VECTOR_HI[ADDR_BITS-1:0];
      S_ADH: begin
        mem_we    = 1'b1;
        mem_addr  = store_addr[ADDR_BITS-1:0];
        mem_wdata = (op == OP_STA) ? acc : idx_y;
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign res.prog_counter = pc;
  assign res.accumulator  = acc;
  assign res.index_x      = idx_x;
  assign res.index_y      = idx_y;
  assign res.status       = status;
  assign res.is_halted    = halted;
  assign res.step_cycles  = cycles;
  assign res.bad_opcode   = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      pc       <= 16'h0000;
      acc      <= 8'h00;
      idx_x    <= 8'h00;
      idx_y    <= 8'h00;
      status   <= STATUS_RESET;
      halted   <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + ADDR_BITS'(1);
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            kind    <= in_kind;
            address <= in_address;
            value   <= in_value;
            cycles  <= CYC_NONE;
            bad     <= 1'b0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (kind)
            KIND_WRITE:   state <= S_DONE;
            KIND_RESTART: state <= S_VLO;
            KIND_SET_PC: begin
              pc    <= address;
              state <= S_DONE;
            end
            KIND_STEP: begin
              if (halted) begin
                state <= S_DONE;
              end else begin
                pc    <= pc + 16'd1;
                state <= S_OP;
              end
            end
          endcase
        end
        S_VLO: begin
          lo    <= mem_rdata;
          state <= S_VHI;
        end
        S_VHI: begin
          pc     <= {mem_rdata, lo};
          acc    <= 8'h00;
          idx_x  <= 8'h00;
          idx_y  <= 8'h00;
          status <= STATUS_RESET;
          halted <= 1'b0;
          state  <= S_DONE;
        end
        S_OP: begin
          op <= mem_rdata;
          // operand read for loads and stores is issued this cycle at pc
          unique case (mem_rdata) inside
            OP_LDA, OP_LDX, OP_LDY: begin
              pc    <= pc + 16'd1;
              state <= S_OPR;
            end
            OP_STA, OP_STY: begin
              pc    <= pc + 16'd1;
              state <= S_ADL;
            end
            OP_BRK: begin
              halted <= 1'b1;
              cycles <= CYC_BRK;
              state  <= S_DONE;
            end
            default: begin
              halted <= 1'b1;
              bad    <= 1'b1;
              state  <= S_DONE;
            end
          endcase
        end
        S_OPR: begin
          case (op)
            OP_LDA:  acc   <= mem_rdata;
            OP_LDX:  idx_x <= mem_rdata;
            default: idx_y <= mem_rdata;
          endcase
          status <= zn_update(status, mem_rdata);
          cycles <= CYC_LOAD;
          state  <= S_DONE;
        end
        S_ADL: begin
          lo    <= mem_rdata;
          pc    <= pc + 16'd1;
          state <= S_ADH;
        end
        S_ADH: begin
          cycles <= CYC_STORE;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/mini_6502_instruction_step_unit.sv =====
// Top level of the mini 6502 step unit: stream ports and result register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: address, value; tuser: kind
//  m_*      out  m_tvalid/m_tready  tdata: pc, a, x, y, status, halted, cycles, bad
//
// One request at a time through a single-port byte memory (one access a cycle):
// a step fetches the opcode unless halted, a load then its operand, a store two
// address bytes and its write; restart reads the reset vector. After reset a
// clearing pass writes all 2^ADDR_BITS (65536) bytes to zero, one a cycle, before
// the first request is taken. The result register lets the next request start
// while a result is unread; one finishing into a full register waits for m_tready.
module mini_6502_instruction_step_unit import m65_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[15:0], value[23:16]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // pc[15:0], a[23:16], x[31:24], y[39:32],
                                 // status[47:40], halted[48], cycles[51:49],
                                 // bad[52], zero[55:53]
);

  logic res_valid;
  logic res_ready;
  res_t res;

  m65_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (kind_t'(s_tuser)),
    .in_address (s_tdata[15:0]),
    .in_value   (s_tdata[23:16]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {3'b000, res.bad_opcode, res.step_cycles, res.is_halted, res.status,
                  res.index_y, res.index_x, res.accumulator, res.prog_counter};
    end
  end

endmodule
